[sv/mhpq_pkg.sv]
// Shared types and codes for the max-heap priority queue.
package mhpq_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned CNT_W = 9;

  // Operation codes carried in the request mode field
  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                    mode;
    logic signed [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] max_value;
    logic [1:0]              status;
    logic [CNT_W-1:0]        entry_count;
  } out_t;

  // One slot of the sorted chain
  typedef struct packed {
    logic                    vld;
    logic signed [KEY_W-1:0] key;
  } slot_t;

  // Broadcast control for every cell of the chain
  typedef struct packed {
    logic                    ins;
    logic                    ext;
    logic signed [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

[sv/mhpq_cell.sv]
// One cell of the sorted key chain: holds a slot and trades it with its neighbors.
module mhpq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  mhpq_pkg::cell_ctl_t ctl,
  input  logic               left_take,
  input  mhpq_pkg::slot_t    left_slot,
  input  mhpq_pkg::slot_t    right_slot,
  output logic               take,
  output mhpq_pkg::slot_t    slot
);

  logic                              vld_r;
  logic                              vld_nxt;
  logic signed [mhpq_pkg::KEY_W-1:0] key_r;
  logic signed [mhpq_pkg::KEY_W-1:0] key_nxt;

  // Claim this place for the new key when empty or holding a smaller key
  always_comb begin
    take = ctl.ins && (!vld_r || (ctl.key > key_r));
  end

  // Shift left on extract; on insert shift right below the new key
  always_comb begin
    vld_nxt = vld_r;
    key_nxt = key_r;
    if (ctl.ext) begin
      vld_nxt = right_slot.vld;
      key_nxt = right_slot.key;
    end else if (take) begin
      if (left_take) begin
        vld_nxt = left_slot.vld;
        key_nxt = left_slot.key;
      end else begin
        vld_nxt = 1'b1;
        key_nxt = ctl.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign slot.vld = vld_r;
  assign slot.key = key_r;

endmodule

[sv/max_heap_priority_queue.sv]
// Priority queue top level: a sorted chain of cells, largest key in cell 0.
// The result of a request is valid in the cycle after it is accepted.
// Throughput: one request per cycle while the result channel is not stalled; every cell
// compares and shifts in parallel, so the path is one 32-bit signed compare plus a slot select per cell.
// Reset (rst_n, synchronous, active low) empties the queue and drops any result.
module max_heap_priority_queue #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mhpq_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mhpq_pkg::out_t out_data
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic                in_fire;
  logic                full;
  logic                empty;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic [CW+mhpq_pkg::CNT_W-1:0] count_ext;
  logic                out_valid_r;
  mhpq_pkg::out_t      out_r;
  mhpq_pkg::out_t      out_nxt;
  mhpq_pkg::cell_ctl_t ctl;

  logic                take_w [CAPACITY];
  mhpq_pkg::slot_t     slot_w [CAPACITY];
  logic [CAPACITY-1:0] vld_vec;

  // Take a request whenever the output register is free or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);

  // Broadcast the operation to every cell
  always_comb begin
    ctl.ins = in_fire && (in_data.mode == mhpq_pkg::MODE_INSERT) && !full;
    ctl.ext = in_fire && (in_data.mode == mhpq_pkg::MODE_EXTRACT) && !empty;
    ctl.key = in_data.key;
  end

  // Build the count and the result
  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.ext) begin
      count_nxt = count_r - CW'(1);
    end
    count_ext = {{mhpq_pkg::CNT_W{1'b0}}, count_nxt};
    out_nxt.max_value   = ctl.ext ? slot_w[0].key : '0;
    out_nxt.entry_count = count_ext[mhpq_pkg::CNT_W-1:0];
    out_nxt.status      = mhpq_pkg::ST_OK;
    if (in_data.mode == mhpq_pkg::MODE_EXTRACT) begin
      if (empty) begin
        out_nxt.status = mhpq_pkg::ST_EMPTY;
      end
    end else if (full) begin
      out_nxt.status = mhpq_pkg::ST_FULL;
    end
  end

  // Chain of cells, largest key at the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic            left_take;
    mhpq_pkg::slot_t left_slot;
    mhpq_pkg::slot_t right_slot;

    if (i == 0) begin : g_head
      assign left_take = 1'b0;
      assign left_slot = '0;
    end else begin : g_mid
      assign left_take = take_w[i-1];
      assign left_slot = slot_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_slot = '0;
    end else begin : g_body
      assign right_slot = slot_w[i+1];
    end

    mhpq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .left_take  (left_take),
      .left_slot  (left_slot),
      .right_slot (right_slot),
      .take       (take_w[i]),
      .slot       (slot_w[i])
    );

    assign vld_vec[i] = slot_w[i].vld;
  end

  // Hold the count and the result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // Occupied cells always match the count
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'($countones(vld_vec)) == count_r))
    else $error("cell occupancy disagrees with count");

  // Head holds the largest key
  a_head_max: assert property (@(posedge clk) disable iff (!rst_n)
    (!slot_w[1].vld || (slot_w[0].key >= slot_w[1].key)))
    else $error("head cell is not the maximum");

  // An accepted request always leaves a result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted request produced no result");

  // A full report only while the queue is full
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status == mhpq_pkg::ST_FULL)) |-> full)
    else $error("full status with free cells");
`endif

endmodule

[bench/testbench.sv]
// Self-checking bench for the max-heap priority queue: random and directed requests.

// Track the queue contents and hold the results that accepted requests must produce
class heap_tracker;
  localparam int unsigned HEAP_CAP = 256;

  logic signed [mhpq_pkg::KEY_W-1:0] slots [HEAP_CAP];
  int unsigned used;
  mhpq_pkg::out_t pending_results[$];
  int unsigned errors;

  function new();
    used = 0;
    errors = 0;
  endfunction

  // Trade two slots of the tracked heap
  function void trade(int unsigned a, int unsigned b);
    logic signed [mhpq_pkg::KEY_W-1:0] tmp;
    tmp = slots[a];
    slots[a] = slots[b];
    slots[b] = tmp;
  endfunction

  // Apply one accepted request and queue the result it must give
  function void note_request(mhpq_pkg::in_t req);
    mhpq_pkg::out_t res;
    int unsigned pos;
    int unsigned up;
    int unsigned lc;
    int unsigned rc;
    int unsigned best;
    res = '0;
    res.status = mhpq_pkg::ST_OK;
    if (req.mode == mhpq_pkg::MODE_INSERT) begin
      if (used >= HEAP_CAP) begin
        res.status = mhpq_pkg::ST_FULL;
      end else begin
        // Place at the end, then climb while strictly greater than the parent
        slots[used] = req.key;
        pos = used;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!(slots[pos] > slots[up])) break;
          trade(pos, up);
          pos = up;
        end
        used++;
      end
    end else begin
      if (used == 0) begin
        res.status = mhpq_pkg::ST_EMPTY;
      end else begin
        // Take the root, move the last key up, and sink it; left child wins ties
        res.max_value = slots[0];
        used--;
        slots[0] = slots[used];
        pos = 0;
        forever begin
          lc = 2 * pos + 1;
          rc = 2 * pos + 2;
          best = pos;
          if (lc < used && slots[lc] > slots[best]) best = lc;
          if (rc < used && slots[rc] > slots[best]) best = rc;
          if (best == pos) break;
          trade(pos, best);
          pos = best;
        end
      end
    end
    res.entry_count = used[mhpq_pkg::CNT_W-1:0];
    pending_results.push_back(res);
  endfunction

  // Compare one delivered result against the oldest queued one
  function void check_result(mhpq_pkg::out_t got);
    mhpq_pkg::out_t want;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result max_value=%0d status=%0d entry_count=%0d",
               $time, got.max_value, got.status, got.entry_count);
      return;
    end
    want = pending_results.pop_front();
    if (got !== want) begin
      errors++;
      $display("%0t: expected max_value=%0d status=%0d entry_count=%0d, got %0d %0d %0d",
               $time, want.max_value, want.status, want.entry_count,
               got.max_value, got.status, got.entry_count);
    end
  endfunction
endclass

module testbench;
  localparam int unsigned HEAP_CAP     = 256;
  localparam int unsigned ITEM_TARGET  = 1950;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  mhpq_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  mhpq_pkg::out_t out_data;

  heap_tracker tracker = new();
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned sent;
  int unsigned cycles;

  max_heap_priority_queue #(.CAPACITY(HEAP_CAP)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("max_heap_priority_queue: mismatch");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every result that is taken
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_result(out_data);
  end

  // Mix extremes, tight ranges that force duplicates, and full-range keys
  function automatic logic signed [mhpq_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0:       pick_key = 32'h8000_0000;
      1:       pick_key = 32'h7fff_ffff;
      2, 3, 4: pick_key = $urandom_range(15) - 8;
      default: pick_key = $urandom;
    endcase
  endfunction

  // Offer one request after a random idle stretch and hold it until taken
  task automatic send_request(logic mode_bit, logic signed [mhpq_pkg::KEY_W-1:0] key_val);
    mhpq_pkg::in_t req;
    req.mode = mode_bit;
    req.key  = key_val;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(req);
    sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every queued result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.pending_results.size() != 0);
  endtask

  task automatic fill_to_full();
    while (tracker.used < HEAP_CAP) send_request(mhpq_pkg::MODE_INSERT, pick_key());
    repeat ($urandom_range(1, 3)) send_request(mhpq_pkg::MODE_INSERT, pick_key());
  endtask

  task automatic empty_out();
    while (tracker.used > 0) send_request(mhpq_pkg::MODE_EXTRACT, pick_key());
    repeat ($urandom_range(1, 3)) send_request(mhpq_pkg::MODE_EXTRACT, pick_key());
  endtask

  // One random sequence: full fill, full drain, heapsort batch, or a loose mix
  task automatic run_burst();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(19);
    if (kind < 2) begin
      fill_to_full();
    end else if (kind < 4) begin
      empty_out();
    end else if (kind < 10) begin
      n = $urandom_range(1, 40);
      repeat (n) send_request(mhpq_pkg::MODE_INSERT, pick_key());
      empty_out();
    end else begin
      n = $urandom_range(10, 60);
      repeat (n) begin
        send_request(($urandom_range(99) < 55) ? mhpq_pkg::MODE_INSERT
                                                : mhpq_pkg::MODE_EXTRACT,
                     pick_key());
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sent = 0;
    cycles = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Extract on empty, key extremes, equal keys, then drain past empty
    send_request(mhpq_pkg::MODE_EXTRACT, 32'h7fff_ffff);
    send_request(mhpq_pkg::MODE_INSERT, 32'h7fff_ffff);
    send_request(mhpq_pkg::MODE_INSERT, 32'h8000_0000);
    send_request(mhpq_pkg::MODE_INSERT, 32'h0000_0000);
    send_request(mhpq_pkg::MODE_INSERT, 32'hffff_ffff);
    send_request(mhpq_pkg::MODE_INSERT, 32'sd5);
    send_request(mhpq_pkg::MODE_INSERT, 32'sd5);
    send_request(mhpq_pkg::MODE_INSERT, 32'hffff_ffff);
    send_request(mhpq_pkg::MODE_INSERT, 32'h7fff_ffff);
    repeat (9) send_request(mhpq_pkg::MODE_EXTRACT, 32'h8000_0000);

    // Reach the full case and back to empty without idling
    fill_to_full();
    empty_out();

    // Advance through the idling phases, pausing the sender at each boundary
    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      while (sent < (phase + 1) * ITEM_TARGET / 4) run_burst();
    end

    drain_results();
    repeat (20) @(posedge clk);
    tracker.errors += tracker.pending_results.size();
    if (tracker.errors == 0) begin
      $display("max_heap_priority_queue: match");
    end else begin
      $display("max_heap_priority_queue: mismatch");
    end
    $finish;
  end
endmodule
